/* rtl/sddw_pkg.sv */
// Shared constants, codes and controller/datapath types for the signed decimal digit writer.
package sddw_pkg;

    localparam int NUM_W           = 32;
    localparam int FIELD_W         = 4;
    localparam int MAX_DIGITS_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [FIELD_W-1:0] CODE_MINUS   = 4'd10;
    localparam logic [FIELD_W-1:0] CODE_BLANK   = 4'd15;
    localparam logic [FIELD_W-1:0] DIGITS_RESET = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_BLANK,
        ST_DIGIT,
        ST_SIGN
    } sddw_state_t;

    typedef enum logic [1:0] {
        EMIT_BLANK,
        EMIT_DIGIT,
        EMIT_SIGN
    } sddw_emit_t;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       pos_down;
        logic       pos_up;
        logic       digit_shift;
        sddw_emit_t emit;
    } sddw_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic pos_is_one;
        logic blank_none;
        logic dig_last;
        logic more_digits;
    } sddw_status_t;

endpackage

/* rtl/sddw_num_if.sv */
// Input channel: one signed number per word.
interface sddw_num_if
    import sddw_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

/* rtl/sddw_wr_if.sv */
// Output channel: one digit-register write per word.
interface sddw_wr_if
    import sddw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] digit_position;
    logic [FIELD_W-1:0] code_value;
    logic               last_write;
    logic               overflow;

    modport source (
        output valid, output digit_position, output code_value,
        output last_write, output overflow, input ready
    );
    modport sink (
        input valid, input digit_position, input code_value,
        input last_write, input overflow, output ready
    );
endinterface

/* rtl/sddw_ctrl.sv */
// Controller: sequences conversion, blanking, digit and sign writes.
module sddw_ctrl
    import sddw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  sddw_status_t status,
    output sddw_cmd_t    cmd
);

    sddw_state_t state_reg;
    sddw_state_t state_next;
    logic        out_ack;

    assign out_ack = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '{load: 1'b0, conv_step: 1'b0, pos_down: 1'b0, pos_up: 1'b0,
                       digit_shift: 1'b0, emit: EMIT_BLANK};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = status.blank_none ? ST_DIGIT : ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                out_valid = 1'b1;
                cmd.emit  = EMIT_BLANK;
                if (out_ack)
                begin
                    // position 1 is kept for the first digit
                    if (status.pos_is_one)
                    begin
                        state_next = ST_DIGIT;
                    end
                    else
                    begin
                        cmd.pos_down = 1'b1;
                    end
                end
            end
            ST_DIGIT:
            begin
                out_valid = 1'b1;
                cmd.emit  = EMIT_DIGIT;
                if (out_ack)
                begin
                    if (status.dig_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!status.more_digits)
                    begin
                        cmd.pos_up = 1'b1;
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        cmd.pos_up      = 1'b1;
                        cmd.digit_shift = 1'b1;
                    end
                end
            end
            ST_SIGN:
            begin
                out_valid = 1'b1;
                cmd.emit  = EMIT_SIGN;
                if (out_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sddw_dpath.sv */
// Datapath: config register, magnitude, bit-serial BCD conversion and write fields.
module sddw_dpath
    import sddw_pkg::*;
#(
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [FIELD_W-1:0]      cfg_wdata,
    input  logic signed [NUM_W-1:0] num_value,
    input  sddw_cmd_t               cmd,
    output sddw_status_t            status,
    output logic [FIELD_W-1:0]      digit_position,
    output logic [FIELD_W-1:0]      code_value,
    output logic                    last_write,
    output logic                    overflow
);

    // enough decimal digits for 2^VALUE_WIDTH - 1
    localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    localparam logic [FIELD_W-1:0] MAX_POS = FIELD_W'(MAX_DIGITS);

    logic [FIELD_W-1:0]     digits_in_use_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       bit_cnt_reg;
    logic [CNT_W-1:0]       bit_cnt_next;
    logic [FIELD_W-1:0]     pos_reg;
    logic [FIELD_W-1:0]     pos_next;
    logic                   blank_none_reg;
    logic                   blank_none_next;
    logic [VALUE_WIDTH-1:0] in_bits;
    logic [FIELD_W-1:0]     blanks;
    logic                   at_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_in_use_reg <= DIGITS_RESET;
        end
        else if (cfg_we)
        begin
            digits_in_use_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        bcd_reg        <= bcd_next;
        bit_cnt_reg    <= bit_cnt_next;
        pos_reg        <= pos_next;
        blank_none_reg <= blank_none_next;
    end

    assign in_bits = num_value[VALUE_WIDTH-1:0];
    assign blanks  = (digits_in_use_reg > MAX_POS) ? MAX_POS : digits_in_use_reg;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        pos_next        = pos_reg;
        blank_none_next = blank_none_reg;
        if (cmd.load)
        begin
            neg_next        = in_bits[VALUE_WIDTH-1];
            mag_next        = in_bits[VALUE_WIDTH-1] ? (~in_bits + VALUE_WIDTH'(1)) : in_bits;
            bcd_next        = '0;
            bit_cnt_next    = '0;
            blank_none_next = (blanks == '0);
            pos_next        = (blanks == '0) ? FIELD_W'(1) : blanks;
        end
        if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + CNT_W'(1);
        end
        if (cmd.digit_shift)
        begin
            bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
        end
        if (cmd.pos_down)
        begin
            pos_next = pos_reg - FIELD_W'(1);
        end
        if (cmd.pos_up)
        begin
            pos_next = pos_reg + FIELD_W'(1);
        end
    end

    assign at_max = (pos_reg == MAX_POS);

    assign status.conv_last   = (bit_cnt_reg == CNT_W'(VALUE_WIDTH - 1));
    assign status.pos_is_one  = (pos_reg == FIELD_W'(1));
    assign status.blank_none  = blank_none_reg;
    assign status.more_digits = |bcd_reg[BCD_W-1:4];
    assign status.dig_last    = at_max || (!status.more_digits && !neg_reg);

    assign digit_position = pos_reg;

    always_comb
    begin
        unique case (cmd.emit)
            EMIT_BLANK:
            begin
                code_value = CODE_BLANK;
                last_write = 1'b0;
                overflow   = 1'b0;
            end
            EMIT_DIGIT:
            begin
                code_value = bcd_reg[3:0];
                last_write = status.dig_last;
                // top position reached with digits or a sign still left
                overflow   = at_max && (status.more_digits || neg_reg);
            end
            EMIT_SIGN:
            begin
                code_value = CODE_MINUS;
                last_write = 1'b1;
                overflow   = 1'b0;
            end
            default:
            begin
                code_value = CODE_BLANK;
                last_write = 1'b0;
                overflow   = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/signed_decimal_digit_writer_top.sv */
// Top level: turns a signed number into a run of code-B digit-register writes.
// An accepted number is converted by the bit-serial BCD shift loop, one magnitude bit per cycle,
//   before its blank, digit and sign writes are offered; numbers are taken one at a time.
// Each write is held until taken; a new number is accepted once the last write is taken.
// Reset: control returns to idle, digits_in_use returns to 3.
module signed_decimal_digit_writer_top
    import sddw_pkg::*;
#(
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_wdata,
    sddw_num_if.sink           num,
    sddw_wr_if.source          wr
);

    sddw_cmd_t    cmd;
    sddw_status_t status;

    sddw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num.valid),
        .in_ready  (num.ready),
        .out_valid (wr.valid),
        .out_ready (wr.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sddw_dpath #(
        .MAX_DIGITS  (MAX_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .num_value      (num.value),
        .cmd            (cmd),
        .status         (status),
        .digit_position (wr.digit_position),
        .code_value     (wr.code_value),
        .last_write     (wr.last_write),
        .overflow       (wr.overflow)
    );

`ifndef SYNTHESIS
    a_ovf_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.overflow |-> wr.last_write)
        else $error("overflow raised on a write that is not last");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid |-> (wr.digit_position >= FIELD_W'(1)) &&
                     (wr.digit_position <= FIELD_W'(MAX_DIGITS)))
        else $error("digit position out of range");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.valid && num.ready))
        else $error("number accepted while a write is pending");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.ready && wr.last_write |=> num.ready)
        else $error("input not ready after last write");

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        num.valid && num.ready |=> !wr.valid && !num.ready)
        else $error("conversion did not start after accept");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the signed decimal digit writer: numbers in, predicted digit writes out.
module testbench
    import sddw_pkg::*;
();

    localparam int MAX_POS      = MAX_DIGITS_DEF;
    localparam int DECIMAL_BASE = 10;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [FIELD_W-1:0] digit_position;
        logic [FIELD_W-1:0] code_value;
        logic               last_write;
        logic               overflow;
    } digit_write_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [FIELD_W-1:0] cfg_wdata;

    sddw_num_if num_ch();
    sddw_wr_if  wr_ch();

    signed_decimal_digit_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .num       (num_ch),
        .wr        (wr_ch)
    );

    logic signed [NUM_W-1:0] pending_numbers[$];
    digit_write_t            expected_writes[$];
    logic [FIELD_W-1:0]      blank_count;
    int                      numbers_queued;
    int                      numbers_taken;
    int                      mismatches;
    int                      send_idle_pct;
    int                      stall_pct;
    int                      hold_left;
    bit                      num_fire;
    digit_write_t            seen_write;
    digit_write_t            due_write;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic digit_write_t make_write(input int pos, input logic [FIELD_W-1:0] code);
        digit_write_t w;
        w.digit_position = FIELD_W'(pos);
        w.code_value     = code;
        w.last_write     = 1'b0;
        w.overflow       = 1'b0;
        return w;
    endfunction

    // Expand one number into its blanking, digit and sign writes.
    function automatic void predict_digit_writes(input logic signed [NUM_W-1:0] number);
        logic [NUM_W-1:0] mag;
        digit_write_t     run[$];
        digit_write_t     w;
        int               blanks;
        int               pos;
        bit               negative;
        bit               dropped;
        negative = number[NUM_W-1];
        mag = number;
        if (negative)
            mag = ~mag + NUM_W'(1);
        dropped = 1'b0;
        blanks = (blank_count > MAX_POS) ? MAX_POS : int'(blank_count);
        for (pos = blanks; pos >= 1; pos--)
            run.push_back(make_write(pos, CODE_BLANK));
        if (mag == 0)
        begin
            run.push_back(make_write(1, FIELD_W'(0)));
        end
        else
        begin
            pos = 0;
            while (mag != 0)
            begin
                pos++;
                if (pos <= MAX_POS)
                    run.push_back(make_write(pos, FIELD_W'(mag % DECIMAL_BASE)));
                else
                    dropped = 1'b1;
                mag = mag / DECIMAL_BASE;
            end
            if (negative)
            begin
                pos++;
                if (pos <= MAX_POS)
                    run.push_back(make_write(pos, CODE_MINUS));
                else
                    dropped = 1'b1;
            end
        end
        w = run.pop_back();
        w.last_write = 1'b1;
        w.overflow   = dropped;
        run.push_back(w);
        foreach (run[i])
            expected_writes.push_back(run[i]);
    endfunction

    // Bias toward digit-count boundaries and the eight-digit edge where the sign drops.
    function automatic logic signed [NUM_W-1:0] random_number();
        logic signed [NUM_W-1:0] v;
        int                      k;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(99);
            2:
            begin
                k = $urandom_range(9);
                v = 10 ** k - 1 + $urandom_range(2);
            end
            3: v = $urandom_range(99999999, 10000000);
            4: v = $urandom_range(9999);
            default: v = $urandom_range(999999999);
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    task automatic queue_number(input logic signed [NUM_W-1:0] v);
        pending_numbers.push_back(v);
        numbers_queued++;
    endtask

    task automatic wait_drained();
        while (numbers_taken != numbers_queued || expected_writes.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [FIELD_W-1:0] digits, input int idle, input int stall,
                             input int count, input int hold);
        cfg_we    <= 1'b1;
        cfg_wdata <= digits;
        @(negedge clk);
        cfg_we      <= 1'b0;
        blank_count = digits;
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_left     = hold;
        repeat (count)
            queue_number(random_number());
        wait_drained();
    endtask

    // Sender: hold the word until taken, then offer the next one or idle.
    always @(negedge clk)
    begin
        if (!rst_n)
            num_ch.valid <= 1'b0;
        else if (!num_ch.valid || num_fire)
        begin
            if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                num_ch.valid <= 1'b1;
                num_ch.value <= pending_numbers.pop_front();
            end
            else
                num_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            wr_ch.ready <= 1'b0;
        else
            wr_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        num_fire <= num_ch.valid && num_ch.ready && rst_n;
        if (rst_n && wr_ch.valid && wr_ch.ready)
        begin
            seen_write = '{wr_ch.digit_position, wr_ch.code_value,
                           wr_ch.last_write, wr_ch.overflow};
            if (expected_writes.size() == 0)
                report_mismatch("write with none pending, digit_position",
                                int'(seen_write.digit_position), 0);
            else
            begin
                due_write = expected_writes.pop_front();
                if (seen_write.digit_position !== due_write.digit_position)
                    report_mismatch("digit_position", int'(seen_write.digit_position),
                                    int'(due_write.digit_position));
                if (seen_write.code_value !== due_write.code_value)
                    report_mismatch("code_value", int'(seen_write.code_value),
                                    int'(due_write.code_value));
                if (seen_write.last_write !== due_write.last_write)
                    report_mismatch("last_write", int'(seen_write.last_write),
                                    int'(due_write.last_write));
                if (seen_write.overflow !== due_write.overflow)
                    report_mismatch("overflow", int'(seen_write.overflow),
                                    int'(due_write.overflow));
            end
        end
        if (rst_n && num_ch.valid && num_ch.ready)
        begin
            numbers_taken++;
            predict_digit_writes(num_ch.value);
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        num_ch.valid   = 1'b0;
        num_ch.value   = '0;
        wr_ch.ready    = 1'b0;
        blank_count    = DIGITS_RESET;
        numbers_queued = 0;
        numbers_taken  = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_left      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words under the reset blank count.
        queue_number(0);
        queue_number(1);
        queue_number(-1);
        queue_number(9);
        queue_number(-9);
        queue_number(10);
        queue_number(-10);
        queue_number(42);
        queue_number(-305);
        queue_number(1234567);
        queue_number(-1234567);
        queue_number(12345678);
        queue_number(-12345678);
        queue_number(99999999);
        queue_number(-99999999);
        queue_number(100000000);
        queue_number(1000000000);
        queue_number(2147483647);
        queue_number(-2147483647);
        queue_number(32'sh8000_0000);
        queue_number(32'sh5555_5555);
        queue_number(32'shAAAA_AAAA);
        wait_drained();

        run_phase(4'd0, 0, 0, 76, 0);
        run_phase(4'd8, 87, 0, 76, 0);
        run_phase(4'd15, 0, 87, 76, 0);
        run_phase(4'd1, 29, 29, 76, 0);
        run_phase(4'd9, 0, 0, 76, HOLD_CYCLES);
        run_phase(4'd6, 29, 29, 76, 0);

        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
